FILE: rtl/lpd_pkg.sv
// shared types, codes and the position decode table for the line position debouncer
package lpd_pkg;

   typedef enum logic [1:0] {
      PAT_LOST     = 2'd0,
      PAT_NOISE    = 2'd1,
      PAT_WIDE     = 2'd2,
      PAT_POSITION = 2'd3
   } pattern_type;

   // register index, taken from paddr[2]
   localparam logic CSR_ADJACENT_STEP_IDX = 1'b0;
   localparam logic CSR_JUMP_FRAMES_IDX   = 1'b1;

   localparam logic [3:0] ADJACENT_STEP_RESET = 4'd1;
   localparam logic [7:0] JUMP_FRAMES_RESET   = 8'd3;
   localparam logic [7:0] COUNT_MAX           = 8'hFF;

   typedef struct packed {
      pattern_type        pattern;
      logic signed [3:0]  position;
   } lpd_class_type;

   typedef struct packed {
      pattern_type        pattern;
      logic signed [3:0]  held_position;
      logic signed [3:0]  pending_position;
      logic [7:0]         candidate_count;
   } lpd_result_type;

   // single set bit i -> 2*i-7, adjacent pair at i and i+1 -> 2*i-6
   function automatic logic signed [3:0] lpd_decode(input logic [7:0] bits);
      logic signed [3:0] pos;
      begin
         case (bits)
            8'h01: pos = -4'sd7;
            8'h03: pos = -4'sd6;
            8'h02: pos = -4'sd5;
            8'h06: pos = -4'sd4;
            8'h04: pos = -4'sd3;
            8'h0C: pos = -4'sd2;
            8'h08: pos = -4'sd1;
            8'h18: pos = 4'sd0;
            8'h10: pos = 4'sd1;
            8'h30: pos = 4'sd2;
            8'h20: pos = 4'sd3;
            8'h60: pos = 4'sd4;
            8'h40: pos = 4'sd5;
            8'hC0: pos = 4'sd6;
            8'h80: pos = 4'sd7;
            default: pos = 4'sd0;
         endcase
         return pos;
      end
   endfunction

endpackage

FILE: rtl/lpd_classify.sv
// frame classifier: lost, noise, wide or position, plus the decoded position
module lpd_classify
   import lpd_pkg::*;
(
   input  logic [7:0]    sensor_bits,
   output lpd_class_type cls
);

   logic [7:0] run_start;
   logic       is_wide;

   // a run starts where a set bit has a clear bit below it
   assign run_start = sensor_bits & ~{sensor_bits[6:0], 1'b0};
   assign is_wide   = |(sensor_bits & {1'b0, sensor_bits[7:1]} & {2'b00, sensor_bits[7:2]});

   always_comb begin
      cls.position = 4'sd0;
      if (sensor_bits == 8'h00) begin
         cls.pattern = PAT_LOST;
      end else if (!$onehot(run_start)) begin
         cls.pattern = PAT_NOISE;
      end else if (is_wide) begin
         cls.pattern = PAT_WIDE;
      end else begin
         cls.pattern  = PAT_POSITION;
         cls.position = lpd_decode(sensor_bits);
      end
   end

endmodule

FILE: rtl/lpd_track.sv
// debounce state: stable position, candidate and repeat counter
module lpd_track
   import lpd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic [3:0]     adjacent_step,
   input  logic [7:0]     jump_accept_frames,
   input  lpd_class_type  cls,
   output lpd_result_type result
);

   logic              stable_valid_ff, stable_valid_in;
   logic signed [3:0] held_ff, held_in;
   logic signed [3:0] pend_ff, pend_in;
   logic [7:0]        count_ff, count_in;
   logic signed [4:0] delta;
   logic [4:0]        delta_abs;
   logic              take;

   assign delta     = 5'(cls.position) - 5'(held_ff);
   assign delta_abs = delta[4] ? 5'(-delta) : 5'(delta);

   always_comb begin
      stable_valid_in = stable_valid_ff;
      held_in         = held_ff;
      pend_in         = pend_ff;
      count_in        = count_ff;
      take            = 1'b0;
      if (cls.pattern != PAT_POSITION) begin
         pend_in  = held_ff;
         count_in = 8'd0;
      end else begin
         if (cls.position == pend_ff && count_ff != 8'd0) begin
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 8'd1;
            end
         end else begin
            pend_in  = cls.position;
            count_in = 8'd1;
         end
         take = !stable_valid_ff || (delta_abs <= {1'b0, adjacent_step}) ||
                (count_in >= jump_accept_frames);
         if (take) begin
            held_in         = cls.position;
            stable_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_valid_ff <= 1'b0;
         held_ff         <= 4'sd0;
         pend_ff         <= 4'sd0;
         count_ff        <= 8'd0;
      end else if (advance) begin
         stable_valid_ff <= stable_valid_in;
         held_ff         <= held_in;
         pend_ff         <= pend_in;
         count_ff        <= count_in;
      end
   end

   assign result.pattern          = cls.pattern;
   assign result.held_position    = held_in;
   assign result.pending_position = pend_in;
   assign result.candidate_count  = count_in;

endmodule

FILE: rtl/line_position_debounce_top.sv
// line position debouncer top level: input register, classify/track, result register, csr
// Takes one 8-bit sensor frame per cycle and returns one result per frame, back to back, while
// neither side stalls. A frame is captured in the input register, then classified and run
// through the debounce update combinationally into the result register, from which the
// result is presented. The debounce state closes its loop combinationally from its own
// registers, which sets the rate at one item per clock when nothing stalls. The two
// registers let the input keep flowing for one extra item while a result is stalled.
module line_position_debounce_top
   import lpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_sensor_bits,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_pattern_type,
   output logic signed [3:0] rsp_held_position,
   output logic signed [3:0] rsp_pending_position,
   output logic [7:0]        rsp_candidate_count,
   output logic [7:0]        rsp_sensor_bits_echo,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_bits_ff;
   logic           out_valid_ff, out_valid_in;
   lpd_result_type out_ff;
   logic [7:0]     out_bits_ff;
   logic [3:0]     adj_step_ff;
   logic [7:0]     jump_frames_ff;
   logic           advance;
   logic           csr_write;
   lpd_class_type  cls;
   lpd_result_type result;

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff & rsp_stall;
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_bits_ff <= req_sensor_bits;
      end
      if (advance) begin
         out_ff      <= result;
         out_bits_ff <= in_bits_ff;
      end
   end

   lpd_classify u_classify (
      .sensor_bits (in_bits_ff),
      .cls         (cls)
   );

   lpd_track u_track (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .adjacent_step      (adj_step_ff),
      .jump_accept_frames (jump_frames_ff),
      .cls                (cls),
      .result             (result)
   );

   assign rsp_valid            = out_valid_ff;
   assign rsp_pattern_type     = out_ff.pattern;
   assign rsp_held_position    = out_ff.held_position;
   assign rsp_pending_position = out_ff.pending_position;
   assign rsp_candidate_count  = out_ff.candidate_count;
   assign rsp_sensor_bits_echo = out_bits_ff;

   // register file, word addressed by paddr[2]
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         adj_step_ff    <= ADJACENT_STEP_RESET;
         jump_frames_ff <= JUMP_FRAMES_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            CSR_ADJACENT_STEP_IDX: adj_step_ff    <= pwdata[3:0];
            CSR_JUMP_FRAMES_IDX:   jump_frames_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_ADJACENT_STEP_IDX: prdata = {28'd0, adj_step_ff};
         CSR_JUMP_FRAMES_IDX:   prdata = {24'd0, jump_frames_ff};
         default:               prdata = 32'd0;
      endcase
   end

endmodule

FILE: rtl/lpd_checker.sv
// port-level checker for the line position debouncer and its bind
module lpd_checker
   import lpd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [1:0]        rsp_pattern_type,
   input logic signed [3:0] rsp_held_position,
   input logic signed [3:0] rsp_pending_position,
   input logic [7:0]        rsp_candidate_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_held_position) &&
      $stable(rsp_pending_position) && $stable(rsp_candidate_count))
      else $error("stalled result item changed");

   a_pos_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pattern_type == PAT_POSITION |-> rsp_candidate_count != 8'd0)
      else $error("position item with zero candidate count");

   a_nonpos_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pattern_type != PAT_POSITION |->
      rsp_candidate_count == 8'd0 && rsp_pending_position == rsp_held_position)
      else $error("candidate not restarted on a non-position item");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind line_position_debounce_top lpd_checker u_lpd_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_pattern_type     (rsp_pattern_type),
   .rsp_held_position    (rsp_held_position),
   .rsp_pending_position (rsp_pending_position),
   .rsp_candidate_count  (rsp_candidate_count)
);

FILE: verif/line_position_debounce_top_test.sv
// self-checking testbench for the line position debouncer: sensor frames in, tracked positions out
module line_position_debounce_top_test;
   import lpd_pkg::*;

   typedef struct packed {
      pattern_type       pattern;
      logic signed [3:0] stable;
      logic signed [3:0] candidate;
      logic [7:0]        count;
      logic [7:0]        echo;
   } frame_result_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [7:0]        req_sensor_bits;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_pattern_type;
   logic signed [3:0] rsp_held_position;
   logic signed [3:0] rsp_pending_position;
   logic [7:0]        rsp_candidate_count;
   logic [7:0]        rsp_sensor_bits_echo;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   line_position_debounce_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sensor_bits(req_sensor_bits),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pattern_type(rsp_pattern_type),
      .rsp_held_position(rsp_held_position),
      .rsp_pending_position(rsp_pending_position),
      .rsp_candidate_count(rsp_candidate_count),
      .rsp_sensor_bits_echo(rsp_sensor_bits_echo),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   logic [7:0]        sensor_frames[$];
   frame_result_type  debounce_results[$];
   frame_result_type  oldest_result;
   int                mismatch_count = 0;
   int                idle_pct = 15;
   logic              req_fire = 1'b0;

   // tracker state and register copies
   logic [3:0]        step_limit;
   logic [7:0]        jump_frames;
   logic              stable_known;
   logic signed [3:0] stable_pos;
   logic signed [3:0] cand_pos;
   logic [7:0]        cand_count;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #3000000;
      $display("line_position_debounce_top: mismatch");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("error: %s got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   function automatic pattern_type classify_frame(input logic [7:0] bits,
                                                  output logic signed [3:0] pos);
      int runs, longest, cur, low, val, i;
      bit seen;
      runs = 0;
      longest = 0;
      cur = 0;
      low = 0;
      seen = 1'b0;
      pos = '0;
      if (bits == 8'h00) return PAT_LOST;
      for (i = 0; i < 8; i++) begin
         if (bits[i]) begin
            if (!seen) begin
               low = i;
               seen = 1'b1;
            end
            if (cur == 0) runs++;
            cur++;
            if (cur > longest) longest = cur;
         end else begin
            cur = 0;
         end
      end
      if (runs > 1) return PAT_NOISE;
      if (longest >= 3) return PAT_WIDE;
      val = (longest == 1) ? 2 * low - 7 : 2 * low - 6;
      pos = val[3:0];
      return PAT_POSITION;
   endfunction

   function automatic void track_frame(input logic [7:0] bits);
      logic signed [3:0] decoded;
      pattern_type       kind;
      int                step;
      frame_result_type  res;
      kind = classify_frame(bits, decoded);
      if (kind != PAT_POSITION) begin
         cand_pos = stable_pos;
         cand_count = 8'd0;
      end else begin
         step = int'(decoded) - int'(stable_pos);
         if (step < 0) step = -step;
         if (decoded == cand_pos && cand_count != 8'd0) begin
            if (cand_count != COUNT_MAX) cand_count = cand_count + 8'd1;
         end else begin
            cand_pos = decoded;
            cand_count = 8'd1;
         end
         if (!stable_known || step <= int'(step_limit) || cand_count >= jump_frames) begin
            stable_pos = decoded;
            stable_known = 1'b1;
         end
      end
      res.pattern = kind;
      res.stable = stable_pos;
      res.candidate = cand_pos;
      res.count = cand_count;
      res.echo = bits;
      debounce_results.push_back(res);
   endfunction

   // frame for a position from -7 to 7: even slots are single bits, odd slots are pairs
   function automatic logic [7:0] position_frame(input int p);
      int slot;
      slot = p + 7;
      if (slot % 2 == 0) return 8'h01 << (slot / 2);
      return 8'h03 << ((slot - 1) / 2);
   endfunction

   task automatic add_position_run(input int p, input int n);
      repeat (n) sensor_frames.push_back(position_frame(p));
   endtask

   task automatic random_track(input int n);
      int made, p, len, r;
      made = 0;
      p = 0;
      while (made < n) begin
         r = $urandom_range(99);
         if (r < 12) begin
            sensor_frames.push_back(8'($urandom_range(255)));
            made++;
         end else if (r < 20) begin
            case ($urandom_range(3))
               0: sensor_frames.push_back(8'h00);
               1: sensor_frames.push_back(8'hFF);
               2: sensor_frames.push_back(8'h07 << $urandom_range(5));
               default: sensor_frames.push_back(8'h81 | (8'h01 << $urandom_range(1, 6)));
            endcase
            made++;
         end else begin
            if ($urandom_range(1) == 0) begin
               p = p + int'($urandom_range(4)) - 2;
               if (p > 7) p = 7;
               if (p < -7) p = -7;
            end else begin
               p = int'($urandom_range(14)) - 7;
            end
            len = ($urandom_range(7) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
            add_position_run(p, len);
            made += len;
         end
      end
   endtask

   // sender holds off until every result is back, then lets the pipe settle
   task automatic drain_results(input int settle_cycles);
      do begin
         @(negedge clock);
         #1;
      end while (sensor_frames.size() != 0 || req_valid || debounce_results.size() != 0);
      repeat (settle_cycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == CSR_ADJACENT_STEP_IDX) step_limit = value[3:0];
      else jump_frames = value[7:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // driver: a new item goes out once the current one has been taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (sensor_frames.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_sensor_bits <= sensor_frames.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // monitor: predict on each accepted item, check each accepted result
   always @(posedge clock) begin
      req_fire <= 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            track_frame(req_sensor_bits);
            req_fire <= 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (debounce_results.size() == 0) begin
               report_mismatch("result with no item pending, echo", rsp_sensor_bits_echo, -1);
            end else begin
               oldest_result = debounce_results.pop_front();
               if (rsp_pattern_type != oldest_result.pattern)
                  report_mismatch("pattern_type", rsp_pattern_type, oldest_result.pattern);
               if (rsp_held_position != oldest_result.stable)
                  report_mismatch("held position", rsp_held_position,
                                  oldest_result.stable);
               if (rsp_pending_position != oldest_result.candidate)
                  report_mismatch("pending position", rsp_pending_position,
                                  oldest_result.candidate);
               if (rsp_candidate_count != oldest_result.count)
                  report_mismatch("candidate_count", rsp_candidate_count,
                                  oldest_result.count);
               if (rsp_sensor_bits_echo != oldest_result.echo)
                  report_mismatch("sensor_bits_echo", rsp_sensor_bits_echo,
                                  oldest_result.echo);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sensor_bits = 8'h00;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      step_limit = ADJACENT_STEP_RESET;
      jump_frames = JUMP_FRAMES_RESET;
      stable_known = 1'b0;
      stable_pos = '0;
      cand_pos = '0;
      cand_count = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no stable value yet, then first position, jumps, noise and every code
      sensor_frames.push_back(8'h00);
      sensor_frames.push_back(8'h05);
      sensor_frames.push_back(8'hFF);
      sensor_frames.push_back(8'h07);
      add_position_run(7, 1);
      add_position_run(-7, 3);
      add_position_run(-6, 1);
      add_position_run(0, 1);
      sensor_frames.push_back(8'h81);
      add_position_run(0, 3);
      add_position_run(1, 1);
      add_position_run(6, 2);
      sensor_frames.push_back(8'h00);
      sensor_frames.push_back(8'hE0);
      for (int p = -5; p <= 5; p++) add_position_run(p, 1);
      sensor_frames.push_back(8'hAA);

      drain_results(4);
      csr_write(CSR_ADJACENT_STEP_IDX, 32'd0);
      csr_write(CSR_JUMP_FRAMES_IDX, 32'd1);
      random_track(80);
      drain_results(0);
      random_track(80);

      drain_results(4);
      csr_write(CSR_ADJACENT_STEP_IDX, 32'd14);
      csr_write(CSR_JUMP_FRAMES_IDX, 32'd255);
      random_track(150);

      // long repeat run saturates the count and finally takes the jump
      drain_results(4);
      csr_write(CSR_ADJACENT_STEP_IDX, 32'd0);
      idle_pct = 0;
      add_position_run(7, 4);
      add_position_run(-7, 300);
      add_position_run(-6, 2);
      random_track(50);
      drain_results(4);
      idle_pct = 15;

      csr_write(CSR_ADJACENT_STEP_IDX, 32'd15);
      csr_write(CSR_JUMP_FRAMES_IDX, 32'd0);
      random_track(150);

      drain_results(4);
      csr_write(CSR_ADJACENT_STEP_IDX, 32'd2);
      csr_write(CSR_JUMP_FRAMES_IDX, 32'd5);
      random_track(110);

      drain_results(4);
      csr_write(CSR_JUMP_FRAMES_IDX, 32'd2);
      random_track(150);

      drain_results(8);
      if (mismatch_count == 0) begin
         $display("line_position_debounce_top: match");
      end else begin
         $display("line_position_debounce_top: mismatch");
      end
      $finish;
   end

endmodule
